// ===== src/ptrie_pkg.sv =====
// Shared types, constants and control structs of the prefix trie engine.
package ptrie_pkg;

    localparam int DEF_NODE_COUNT    = 1024;
    localparam int DEF_ALPHABET_SIZE = 26;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_SEARCH = 2'd1,
        REQ_PREFIX = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_FINISH,
        ST_RESULT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic lookup;
        logic mark_read;
        logic load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic need_walk;
        logic item_last;
        logic word_last;
    } t_status;

endpackage

// ===== src/ptrie_ram.sv =====
// Generic simple dual-port RAM with registered read.
module ptrie_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/ptrie_ctrl.sv =====
// Controller state machine of the prefix trie engine.
module ptrie_ctrl
    import ptrie_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (i_status.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    if (i_status.need_walk) begin
                        n_state = ST_LOOKUP;
                    end else if (i_status.item_last) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                n_state    = i_status.word_last ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH: begin
                cmd.mark_read = 1'b1;
                n_state       = ST_RESULT;
            end
            ST_RESULT: begin
                // hold the result until the output register frees up
                if (!r_out_valid || !i_out_stall) begin
                    cmd.load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== src/ptrie_dp.sv =====
// Datapath of the prefix trie engine: walk registers, node pool and tables.
module ptrie_dp
    import ptrie_pkg::*;
#(
    parameter int NODE_COUNT    = DEF_NODE_COUNT,
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    input  logic [1:0] i_req_type,
    input  logic [4:0] i_letter,
    input  logic       i_is_last,
    input  logic       i_empty_word,
    output logic       o_found,
    output logic       o_pool_full
);

    localparam int TABLE_DEPTH = NODE_COUNT * ALPHABET_SIZE;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int LET_W       = $clog2(ALPHABET_SIZE);
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);

    t_req              r_kind;
    logic              r_last;
    logic [NODE_W-1:0] r_cursor;
    logic              r_path_missing;
    logic              r_insert_failed;
    logic [NODE_W:0]   r_next_free;
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] r_clr;
    logic              r_found;
    logic              r_pool_full;

    t_req              kind_in;
    logic [LET_W-1:0]  letter_idx;
    logic [SLOT_W-1:0] slot_calc;
    logic              need_walk;

    logic              tbl_wr_en;
    logic [SLOT_W-1:0] tbl_wr_addr;
    logic [NODE_W-1:0] tbl_wr_data;
    logic [NODE_W-1:0] tbl_rd_data;
    logic              child_none;
    logic              pool_empty;
    logic              alloc;

    logic              em_wr_en;
    logic [NODE_W-1:0] em_wr_addr;
    logic              em_wr_data;
    logic              em_rd_data;

    logic              walk_ok;
    logic              res_found;
    logic              res_full;
    logic              mark_end;

    // Unused request code decodes as a prefix check
    always_comb begin
        if (i_req_type == REQ_INSERT) begin
            kind_in = REQ_INSERT;
        end else if (i_req_type == REQ_SEARCH) begin
            kind_in = REQ_SEARCH;
        end else begin
            kind_in = REQ_PREFIX;
        end
    end

    // Saturate letters beyond the alphabet to the last letter
    assign letter_idx = ({27'd0, i_letter} >= 32'(ALPHABET_SIZE))
                      ? LET_W'(ALPHABET_SIZE - 1) : LET_W'(i_letter);
    assign slot_calc  = SLOT_W'(r_cursor) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(letter_idx);
    assign need_walk  = !i_empty_word && !r_path_missing && !r_insert_failed;

    assign child_none = (tbl_rd_data == '0);
    assign pool_empty = (r_next_free == (NODE_W+1)'(NODE_COUNT));
    assign alloc      = i_cmd.lookup && child_none && (r_kind == REQ_INSERT) && !pool_empty;

    always_comb begin
        if (i_cmd.clear_step) begin
            tbl_wr_en   = 1'b1;
            tbl_wr_addr = r_clr;
            tbl_wr_data = '0;
        end else begin
            tbl_wr_en   = alloc;
            tbl_wr_addr = r_slot;
            tbl_wr_data = r_next_free[NODE_W-1:0];
        end
    end

    assign walk_ok = !r_path_missing && !r_insert_failed;

    always_comb begin
        res_found = 1'b0;
        res_full  = 1'b0;
        mark_end  = 1'b0;
        case (r_kind)
            REQ_INSERT: begin
                res_found = walk_ok;
                res_full  = r_insert_failed;
                mark_end  = walk_ok;
            end
            REQ_SEARCH: begin
                res_found = walk_ok && em_rd_data;
            end
            default: begin
                res_found = walk_ok;
            end
        endcase
    end

    always_comb begin
        if (i_cmd.clear_step) begin
            em_wr_en   = (r_clr < SLOT_W'(NODE_COUNT));
            em_wr_addr = r_clr[NODE_W-1:0];
            em_wr_data = 1'b0;
        end else begin
            em_wr_en   = i_cmd.load && mark_end;
            em_wr_addr = r_cursor;
            em_wr_data = 1'b1;
        end
    end

    ptrie_ram #(
        .WIDTH (NODE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_child_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data),
        .i_rd_en   (i_cmd.accept && need_walk),
        .i_rd_addr (slot_calc),
        .o_rd_data (tbl_rd_data)
    );

    ptrie_ram #(
        .WIDTH (1),
        .DEPTH (NODE_COUNT)
    ) u_end_ram (
        .i_clk     (i_clk),
        .i_wr_en   (em_wr_en),
        .i_wr_addr (em_wr_addr),
        .i_wr_data (em_wr_data),
        .i_rd_en   (i_cmd.mark_read),
        .i_rd_addr (r_cursor),
        .o_rd_data (em_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor        <= '0;
            r_path_missing  <= 1'b0;
            r_insert_failed <= 1'b0;
            r_next_free     <= (NODE_W+1)'(1);
            r_clr           <= '0;
        end else begin
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + SLOT_W'(1);
            end
            if (i_cmd.lookup) begin
                if (!child_none) begin
                    r_cursor <= tbl_rd_data;
                end else if (r_kind != REQ_INSERT) begin
                    r_path_missing <= 1'b1;
                end else if (pool_empty) begin
                    r_insert_failed <= 1'b1;
                end else begin
                    r_cursor    <= r_next_free[NODE_W-1:0];
                    r_next_free <= r_next_free + (NODE_W+1)'(1);
                end
            end
            // return to the root once the word completes
            if (i_cmd.load) begin
                r_cursor        <= '0;
                r_path_missing  <= 1'b0;
                r_insert_failed <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= kind_in;
            r_last <= i_is_last || i_empty_word;
            r_slot <= slot_calc;
        end
        if (i_cmd.load) begin
            r_found     <= res_found;
            r_pool_full <= res_full;
        end
    end

    assign o_status.clear_done = (r_clr == SLOT_W'(TABLE_DEPTH - 1));
    assign o_status.need_walk  = need_walk;
    assign o_status.item_last  = i_is_last || i_empty_word;
    assign o_status.word_last  = r_last;

    assign o_found     = r_found;
    assign o_pool_full = r_pool_full;

endmodule

// ===== src/prefix_trie_engine.sv =====
// Top level of the prefix trie engine: controller, datapath and ports.
//
// Lower-case trie in a pool of NODE_COUNT nodes, fed one letter per input
// transaction; one result transaction follows the last letter of each word.
// After reset the child table and end marks are swept to zero, one entry a
// cycle, across all NODE_COUNT*ALPHABET_SIZE entries (26624 by default);
// input stays stalled during that sweep. A letter that is not the last of its
// word reads the child table (registered read), then follows or allocates the
// child. The last letter adds an end mark read and the result load; an empty
// word has only those two. A letter after a missing path or a full pool skips
// the table read, and adds the same two steps when it ends the word.
// Output is registered, so input is taken while a result waits, except at a
// word's end, which waits for the output register to free up.
module prefix_trie_engine
    import ptrie_pkg::*;
#(
    parameter int NODE_COUNT    = DEF_NODE_COUNT,
    parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_req_type,
    input  logic [4:0] i_letter,
    input  logic       i_is_last,
    input  logic       i_empty_word,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_found,
    output logic       o_pool_full
);

    t_cmd    cmd;
    t_status status;

    ptrie_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ptrie_dp #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_req_type   (i_req_type),
        .i_letter     (i_letter),
        .i_is_last    (i_is_last),
        .i_empty_word (i_empty_word),
        .o_found      (o_found),
        .o_pool_full  (o_pool_full)
    );

endmodule

// ===== src/ptrie_checker.sv =====
// Port-level assertions of the prefix trie engine and their bind.
module ptrie_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_is_last,
    input logic       i_empty_word,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_found,
    input logic       o_pool_full
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_found)
        && $stable(o_pool_full))
        else $error("stalled result transaction dropped or changed");

    // Never report success and a full pool together
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && o_pool_full))
        else $error("found and pool_full both set");

    // Stall input out of reset, as the table sweep begins
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during clearing pass");

    // A letter in the middle of a word gives no result
    a_no_mid_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_is_last && !i_empty_word
        |=> !$rose(o_out_valid))
        else $error("result transaction on a non-final letter");

endmodule

bind prefix_trie_engine ptrie_checker u_ptrie_checker (.*);

// ===== test/prefix_trie_engine_test.sv =====
// Testbench for prefix_trie_engine: random and directed words checked against a trie predictor.
`timescale 1ns / 1ps

module prefix_trie_engine_test;
    import ptrie_pkg::*;

    localparam int NODES = DEF_NODE_COUNT;
    localparam int ALPHA = DEF_ALPHABET_SIZE;
    localparam logic [1:0] REQ_UNUSED = 2'd3;   // decoded by the block as a prefix check
    localparam byte CHAR_BASE = "a";
    localparam int ITEMS_PER_PHASE = 120;

    typedef struct packed {
        logic [1:0] kind;
        logic [4:0] letter;
        logic       last;
        logic       empty;
    } t_letter_txn;

    typedef struct packed {
        logic found;
        logic pool_full;
    } t_trie_answer;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic [1:0] i_req_type = '0;
    logic [4:0] i_letter = '0;
    logic       i_is_last = 1'b0;
    logic       i_empty_word = 1'b0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_found;
    logic       o_pool_full;

    prefix_trie_engine dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_letter     (i_letter),
        .i_is_last    (i_is_last),
        .i_empty_word (i_empty_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_found      (o_found),
        .o_pool_full  (o_pool_full)
    );

    always #6 i_clk = ~i_clk;

    // Trie predictor state
    int unsigned child_of [NODES*ALPHA];
    bit          word_end [NODES];
    int unsigned walk_node = 0;
    bit          walk_missing = 1'b0;
    bit          walk_failed = 1'b0;
    int unsigned free_node = 1;

    t_letter_txn  letter_txns [$];
    t_trie_answer answers_q [$];
    string        word_bank [$];
    int           send_idle_pct = 0;
    int           out_stall_pct = 0;
    int           err_count = 0;
    int           items_queued = 0;

    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 40)
            $display("ERROR t=%0t %s", $time, msg);
    endtask

    // Walk one letter transaction through the predicted trie; queue the answer on a word's end.
    task automatic trie_step(input t_letter_txn txn);
        t_req         kind;
        int unsigned  l;
        int unsigned  slot;
        int unsigned  nxt;
        logic         last;
        t_trie_answer ans;
        kind = (txn.kind == REQ_UNUSED) ? REQ_PREFIX : t_req'(txn.kind);
        last = txn.last || txn.empty;
        if (!txn.empty && !walk_missing && !walk_failed) begin
            l = (txn.letter >= ALPHA) ? ALPHA - 1 : txn.letter;
            slot = walk_node * ALPHA + l;
            nxt = child_of[slot];
            if (nxt != 0) begin
                walk_node = nxt;
            end else if (kind != REQ_INSERT) begin
                walk_missing = 1'b1;
            end else if (free_node >= NODES) begin
                walk_failed = 1'b1;
            end else begin
                child_of[slot] = free_node;
                walk_node = free_node;
                free_node++;
            end
        end
        if (last) begin
            ans = '0;
            if (kind == REQ_INSERT) begin
                if (walk_failed) begin
                    ans.pool_full = 1'b1;
                end else if (!walk_missing) begin
                    word_end[walk_node] = 1'b1;
                    ans.found = 1'b1;
                end
            end else if (!walk_missing && !walk_failed) begin
                ans.found = (kind == REQ_SEARCH) ? word_end[walk_node] : 1'b1;
            end
            answers_q.push_back(ans);
            walk_node = 0;
            walk_missing = 1'b0;
            walk_failed = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin : drive_letters
        t_letter_txn txn;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                trie_step({i_req_type, i_letter, i_is_last, i_empty_word});
            // hold a stalled transaction, otherwise advance or idle
            if (!i_in_valid || !o_in_stall) begin
                if (letter_txns.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    txn = letter_txns.pop_front();
                    i_req_type   <= txn.kind;
                    i_letter     <= txn.letter;
                    i_is_last    <= txn.last;
                    i_empty_word <= txn.empty;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_answers
        t_trie_answer exp_ans;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (answers_q.size() == 0) begin
                    report_mismatch("result transaction with no word pending");
                end else begin
                    exp_ans = answers_q.pop_front();
                    if (o_found !== exp_ans.found)
                        report_mismatch($sformatf("found %b, expected %b",
                                                  o_found, exp_ans.found));
                    if (o_pool_full !== exp_ans.pool_full)
                        report_mismatch($sformatf("pool_full %b, expected %b",
                                                  o_pool_full, exp_ans.pool_full));
                end
            end
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    task automatic push_letter(input logic [1:0] kind, input logic [4:0] letter,
                               input logic last, input logic empty);
        letter_txns.push_back({kind, letter, last, empty});
        items_queued++;
    endtask

    // An empty string goes out as a single empty-word transaction with junk in the letter and last fields.
    task automatic push_word(input logic [1:0] kind, input string w);
        if (w.len() == 0) begin
            push_letter(kind, 5'($urandom_range(31)), 1'($urandom_range(1)), 1'b1);
        end else begin
            for (int i = 0; i < w.len(); i++)
                push_letter(kind, 5'(w[i] - CHAR_BASE), i == w.len() - 1, 1'b0);
        end
    endtask

    function automatic string rand_word(input int len, input int span);
        string s;
        byte   c;
        s = "";
        for (int i = 0; i < len; i++) begin
            c = CHAR_BASE + byte'($urandom_range(span - 1));
            s = $sformatf("%s%c", s, c);
        end
        return s;
    endfunction

    function automatic string bank_word();
        if (word_bank.size() == 0)
            return rand_word($urandom_range(1, 4), 4);
        return word_bank[$urandom_range(word_bank.size() - 1)];
    endfunction

    task automatic queue_random_words(input int n_items);
        int    start;
        int    r;
        int    len;
        int    cut;
        string w;
        start = items_queued;
        while (items_queued - start < n_items) begin
            r = $urandom_range(99);
            if (r < 45) begin
                if (word_bank.size() != 0 && $urandom_range(4) == 0)
                    w = bank_word();
                else
                    w = rand_word($urandom_range(1, 8), ($urandom_range(2) == 0) ? 4 : 26);
                push_word(REQ_INSERT, w);
                word_bank.push_back(w);
            end else if (r < 65) begin
                w = bank_word();
                if ($urandom_range(3) == 0)
                    w = {w, rand_word(1, 4)};
                push_word(REQ_SEARCH, w);
            end else if (r < 75) begin
                w = bank_word();
                if (w.len() > 0) begin
                    cut = $urandom_range(1, w.len());
                    w = w.substr(0, cut - 1);
                end
                push_word(($urandom_range(1) != 0) ? REQ_UNUSED : REQ_PREFIX, w);
            end else if (r < 80) begin
                push_word(2'($urandom_range(3)), "");
            end else if (r < 90) begin
                push_word(2'($urandom_range(1, 3)), rand_word($urandom_range(1, 6), 26));
            end else begin
                // mixed kinds, out-of-range letters, empty word mid-walk
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    if (i > 0 && $urandom_range(5) == 0) begin
                        push_letter(2'($urandom_range(3)), 5'($urandom_range(31)),
                                    1'($urandom_range(1)), 1'b1);
                        break;
                    end
                    push_letter(2'($urandom_range(3)), 5'($urandom_range(31)),
                                i == len - 1, 1'b0);
                end
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (letter_txns.size() != 0 || i_in_valid || answers_q.size() != 0);
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        @(negedge i_clk);
        send_idle_pct = send_pct;
        out_stall_pct = stall_pct;
    endtask

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed words
        push_word(REQ_SEARCH, "");
        push_word(REQ_PREFIX, "");
        push_word(REQ_INSERT, "");
        push_word(REQ_SEARCH, "");
        push_word(REQ_INSERT, "az");
        push_word(REQ_SEARCH, "az");
        push_word(REQ_SEARCH, "a");
        push_word(REQ_UNUSED, "a");
        push_word(REQ_PREFIX, "cba");
        push_letter(REQ_INSERT, 5'h1f, 1'b1, 1'b0);
        push_word(REQ_SEARCH, "z");
        push_letter(REQ_INSERT, 5'd0, 1'b0, 1'b0);
        push_letter(REQ_SEARCH, 5'd25, 1'b1, 1'b0);
        push_letter(REQ_SEARCH, 5'd16, 1'b0, 1'b0);
        push_letter(REQ_INSERT, 5'd0, 1'b1, 1'b0);
        push_letter(REQ_INSERT, 5'd1, 1'b0, 1'b0);
        push_letter(REQ_INSERT, 5'd7, 1'b0, 1'b1);
        push_word(REQ_SEARCH, "b");
        wait_drained();

        set_idling(0, 0);
        queue_random_words(ITEMS_PER_PHASE);
        wait_drained();
        set_idling(76, 0);
        queue_random_words(ITEMS_PER_PHASE);
        wait_drained();
        set_idling(0, 76);
        queue_random_words(ITEMS_PER_PHASE);
        wait_drained();
        set_idling(7, 7);
        queue_random_words(ITEMS_PER_PHASE);
        wait_drained();

        // use up the node pool, then keep working on a full trie
        while (free_node < NODES) begin
            repeat (8) push_word(REQ_INSERT, rand_word(12, 26));
            wait_drained();
        end
        queue_random_words(150);
        wait_drained();

        repeat (30) @(posedge i_clk);
        if (answers_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", answers_q.size()));
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin : watchdog
        #15_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ptrie_pkg.sv
src/ptrie_ram.sv
src/ptrie_ctrl.sv
src/ptrie_dp.sv
src/prefix_trie_engine.sv
src/ptrie_checker.sv
test/prefix_trie_engine_test.sv
